>>> design/thermal_frame_checker_macros.svh
// assertion macros for the thermal frame checker rtl
`ifndef THERMAL_FRAME_CHECKER_MACROS_SVH
`define THERMAL_FRAME_CHECKER_MACROS_SVH

// checked on every rising edge, ignored while reset is held
`define TFC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// checked on every rising edge, reset included
`define TFC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

>>> design/tfc_pkg.sv
// shared constants, types and crc function of the thermal frame checker
package tfc_pkg;

    localparam int PIXELS    = 16;
    localparam int SAMPLES   = 8;
    localparam int FRAME_LEN = 2 + 2 * PIXELS + 1;

    localparam int POS_W  = 6;
    localparam int CNT_W  = 4;
    localparam int TEMP_W = 15;

    localparam logic [7:0]        CRC_POLY        = 8'h07;
    localparam logic [TEMP_W-1:0] MARGIN_TENTHS   = 15'd20;
    localparam logic [TEMP_W-1:0] TEMP_TOP        = 15'h7fff;
    localparam logic [6:0]        RESET_DEV_ADDR  = 7'd10;
    localparam logic [15:0]       RESET_THRESHOLD = 16'd375;

    localparam logic REG_DEV_ADDR  = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    typedef enum logic [1:0] {
        CMD_FRAME_BYTE  = 2'd0,
        CMD_START       = 2'd1,
        CMD_RESET_BATCH = 2'd2
    } cmd_t;

    typedef struct packed {
        logic              close;
        logic              pec_ok;
        logic [15:0]       ref_temp;
        logic [TEMP_W-1:0] peak;
    } frame_result_t;

    // crc-8, msb first, one byte unrolled
    function automatic logic [7:0] crc8(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

>>> design/tfc_frame_parse.sv
// frame byte parser: position, running crc, reference word and frame peak
module tfc_frame_parse
    import tfc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          byte_en,
    input  logic [7:0]    frame_byte,
    input  logic          first_byte,
    input  logic [7:0]    seed_crc,
    output frame_result_t res
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        low_reg, low_next;
    logic [15:0]       ref_reg, ref_next;
    logic [TEMP_W-1:0] peak_reg, peak_next;

    logic              start;
    logic [POS_W-1:0]  pos_eff;
    logic [7:0]        crc_eff;
    logic [TEMP_W-1:0] peak_eff;
    logic [15:0]       word;

    always_comb begin
        start    = first_byte || (pos_reg == '0);
        pos_eff  = start ? '0 : pos_reg;
        crc_eff  = start ? seed_crc : crc_reg;
        peak_eff = start ? '0 : peak_reg;
        word     = {frame_byte, low_reg};

        pos_next  = pos_reg;
        crc_next  = crc_reg;
        low_next  = low_reg;
        ref_next  = ref_reg;
        peak_next = peak_reg;
        res       = '0;

        if (byte_en) begin
            if (pos_eff < POS_W'(FRAME_LEN - 1)) begin
                crc_next  = crc8(frame_byte ^ crc_eff);
                pos_next  = pos_eff + 1'b1;
                peak_next = peak_eff;
                if (!pos_eff[0]) begin
                    low_next = frame_byte;
                end else if (pos_eff == POS_W'(1)) begin
                    ref_next = word;
                end else if (!word[15] && (word[14:0] > peak_eff)) begin
                    // negative pixels never beat the zero floor
                    peak_next = word[14:0];
                end
            end else begin
                // code byte closes the frame
                pos_next     = '0;
                crc_next     = crc_eff;
                peak_next    = peak_eff;
                res.close    = 1'b1;
                res.pec_ok   = (crc_eff == frame_byte);
                res.ref_temp = ref_reg;
                res.peak     = peak_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            crc_reg  <= '0;
            low_reg  <= '0;
            ref_reg  <= '0;
            peak_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            crc_reg  <= crc_next;
            low_reg  <= low_next;
            ref_reg  <= ref_next;
            peak_reg <= peak_next;
        end
    end

endmodule

>>> design/thermal_frame_checker.sv
// thermal frame checker top: input register, batch tracking, result register
// an item passes the input register and then the result register to its result
// one item per cycle unless stalled; input and result registers advance together
// a stalled result register holds the pipe only while it cannot be emptied
// reset (aresetn low, synchronous) clears parse, sampling and batch state
// and loads the register reset values; no result is pending after reset
`include "thermal_frame_checker_macros.svh"

module thermal_frame_checker
    import tfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame_byte[7:0]
    input  logic [2:0]  s_tuser,   // cmd[1:0], first_byte[2]

    output logic        m_tvalid,
    input  logic        m_tready,
    // pec_ok[0], reference_temp[16:1], frame_peak[31:17], reported_temp[46:32],
    // temp_fail[47]
    output logic [47:0] m_tdata,
    output logic [2:0]  m_tuser    // frame_done[0], batch_done[1], reset_done[2]
);

    logic [7:0]        seed_crc_reg;
    logic [15:0]       thr_reg;

    logic              in_valid_reg;
    logic [1:0]        in_cmd_reg;
    logic [7:0]        in_byte_reg;
    logic              in_first_reg;

    logic              sampling_reg, sampling_next;
    logic [CNT_W-1:0]  samples_reg, samples_next;
    logic [TEMP_W-1:0] batch_peak_reg, batch_peak_next;

    logic              m_valid_reg;
    logic [47:0]       m_tdata_reg;
    logic [2:0]        m_tuser_reg;

    logic              advance;
    logic              byte_en;
    frame_result_t     fres;

    logic              has_result;
    logic [47:0]       res_data;
    logic [2:0]        res_user;
    logic [TEMP_W-1:0] bp_new;
    logic [CNT_W-1:0]  cnt_new;
    logic [TEMP_W:0]   rep_sum;
    logic [TEMP_W-1:0] rep;
    logic              fail;
    logic              bdone;

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign byte_en  = advance && (in_cmd_reg == CMD_FRAME_BYTE);

    tfc_frame_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_en    (byte_en),
        .frame_byte (in_byte_reg),
        .first_byte (in_first_reg),
        .seed_crc   (seed_crc_reg),
        .res        (fres)
    );

    always_comb begin
        sampling_next   = sampling_reg;
        samples_next    = samples_reg;
        batch_peak_next = batch_peak_reg;
        has_result      = 1'b0;
        res_data        = '0;
        res_user        = '0;
        bp_new  = (fres.peak > batch_peak_reg) ? fres.peak : batch_peak_reg;
        cnt_new = samples_reg + 1'b1;
        rep_sum = {1'b0, bp_new} + {1'b0, MARGIN_TENTHS};
        rep     = rep_sum[TEMP_W] ? TEMP_TOP : rep_sum[TEMP_W-1:0];
        fail    = ($signed({1'b0, rep}) >= $signed(thr_reg));
        bdone   = 1'b0;

        if (advance) begin
            case (in_cmd_reg)
                CMD_FRAME_BYTE: begin
                    if (fres.close) begin
                        if (fres.pec_ok && sampling_reg) begin
                            if (cnt_new >= CNT_W'(SAMPLES)) begin
                                bdone           = 1'b1;
                                sampling_next   = 1'b0;
                                samples_next    = '0;
                                batch_peak_next = '0;
                            end else begin
                                samples_next    = cnt_new;
                                batch_peak_next = bp_new;
                            end
                        end
                        has_result = 1'b1;
                        res_user   = {1'b0, bdone, 1'b1};
                        res_data   = {bdone & fail, bdone ? rep : '0, fres.peak,
                                      fres.ref_temp, fres.pec_ok};
                    end
                end
                CMD_START: begin
                    sampling_next = 1'b1;
                end
                CMD_RESET_BATCH: begin
                    batch_peak_next = '0;
                    has_result      = 1'b1;
                    res_user        = 3'b100;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_crc_reg   <= crc8({RESET_DEV_ADDR, 1'b1});
            thr_reg        <= RESET_THRESHOLD;
            in_valid_reg   <= 1'b0;
            sampling_reg   <= 1'b0;
            samples_reg    <= '0;
            batch_peak_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_DEV_ADDR:  seed_crc_reg <= crc8({cfg_wdata[6:0], 1'b1});
                    REG_THRESHOLD: thr_reg      <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            sampling_reg   <= sampling_next;
            samples_reg    <= samples_next;
            batch_peak_reg <= batch_peak_next;
            if (advance) begin
                m_valid_reg <= has_result;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= s_tuser[1:0];
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[2];
        end
        if (advance && has_result) begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= res_user;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `TFC_ASSERT(a_batch_in_frame, m_tvalid && m_tuser[1] |-> m_tuser[0],
                "batch completion outside a frame result")
    `TFC_ASSERT(a_reset_alone, m_tvalid && m_tuser[2] |-> !m_tuser[0] && (m_tdata == '0),
                "batch reset result carries frame data")
    `TFC_ASSERT(a_fail_needs_batch, m_tvalid && m_tdata[47] |-> m_tuser[1],
                "verdict without batch completion")
    `TFC_ASSERT(a_count_range, samples_reg < CNT_W'(SAMPLES),
                "sample count past batch size")
    `TFC_ASSERT(a_batch_stops, advance && bdone |=> !sampling_reg && (batch_peak_reg == '0),
                "sampling still on after batch completion")

endmodule

>>> dv/tb_thermal_frame_checker.sv
`timescale 1ns / 100ps
// self-checking testbench for the thermal frame checker: directed table, then random frames, controls and loose bytes
module tb_thermal_frame_checker
    import tfc_pkg::*;
();

    localparam int STALL_LIMIT = 2000;
    localparam int SEG_ITEMS   = 170;
    localparam int N_DIRECTED  = 16;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic              frame_done;
        logic              pec_ok;
        logic [15:0]       ref_temp;
        logic [TEMP_W-1:0] frame_peak;
        logic              batch_done;
        logic [TEMP_W-1:0] reported;
        logic              temp_fail;
        logic              reset_done;
    } frame_report_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_ACK
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cmd;
        logic [7:0]  data;
        logic        first;
    } stim_row_t;

    localparam frame_report_t RESET_ACK = '{reset_done: 1'b1, default: '0};

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{ROW_ACK,     CMD_RESET_BATCH, 8'h00, 1'b0},
        '{ROW_NONE,    CMD_UNUSED,      8'hff, 1'b1},
        '{ROW_NONE,    CMD_START,       8'h00, 1'b0},
        '{ROW_NONE,    CMD_START,       8'hff, 1'b1},
        '{ROW_NONE,    CMD_FRAME_BYTE,  8'h00, 1'b1},
        '{ROW_NONE,    CMD_FRAME_BYTE,  8'hff, 1'b0},
        '{ROW_NONE,    CMD_FRAME_BYTE,  8'h12, 1'b1},
        '{ROW_PREDICT, CMD_FRAME_BYTE,  8'h80, 1'b0},
        '{ROW_PREDICT, CMD_FRAME_BYTE,  8'h7f, 1'b0},
        '{ROW_PREDICT, CMD_FRAME_BYTE,  8'hff, 1'b0},
        '{ROW_ACK,     CMD_RESET_BATCH, 8'h55, 1'b0},
        '{ROW_PREDICT, CMD_FRAME_BYTE,  8'h01, 1'b0},
        '{ROW_NONE,    CMD_UNUSED,      8'h00, 1'b0},
        '{ROW_NONE,    CMD_FRAME_BYTE,  8'hff, 1'b1},
        '{ROW_ACK,     CMD_RESET_BATCH, 8'hff, 1'b1},
        '{ROW_NONE,    CMD_START,       8'haa, 1'b1}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    int src_idle_pct;
    int snk_idle_pct;
    int items_sent;
    int mismatches;
    int stall_cycles;

    frame_report_t pending_reports [$];

    // predictor copy of the block state and registers
    logic [6:0]        dev_addr_q;
    logic [15:0]       threshold_q;
    logic [7:0]        crc_q;
    int                pos_q;
    logic [7:0]        low_q;
    logic [15:0]       ref_q;
    logic [TEMP_W-1:0] peak_q;
    bit                sampling_q;
    int                taken_q;
    logic [TEMP_W-1:0] batch_peak_q;

    thermal_frame_checker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    function automatic logic [7:0] crc07(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic predict_item(input logic [1:0] cmd, input logic [7:0] b, input logic first,
                                output bit has, output frame_report_t r);
        logic [15:0] word;
        int          rep;
        has = 0;
        r   = '0;
        if (cmd == CMD_START) begin
            sampling_q = 1;
        end else if (cmd == CMD_RESET_BATCH) begin
            batch_peak_q = '0;
            has = 1;
            r.reset_done = 1'b1;
        end else if (cmd == CMD_FRAME_BYTE) begin
            if (first || pos_q == 0) begin
                pos_q  = 0;
                peak_q = '0;
                crc_q  = crc07({dev_addr_q, 1'b1});
            end
            if (pos_q < FRAME_LEN - 1) begin
                crc_q = crc07(crc_q ^ b);
                if (pos_q % 2 == 0) begin
                    low_q = b;
                end else begin
                    word = {b, low_q};
                    if (pos_q == 1)
                        ref_q = word;
                    else if (int'($signed(word)) > int'(peak_q))
                        peak_q = word[TEMP_W-1:0];
                end
                pos_q++;
            end else begin
                // code byte closes the frame
                has = 1;
                r.frame_done = 1'b1;
                r.pec_ok     = (crc_q == b);
                r.ref_temp   = ref_q;
                r.frame_peak = peak_q;
                if (r.pec_ok && sampling_q) begin
                    if (peak_q > batch_peak_q)
                        batch_peak_q = peak_q;
                    taken_q = (taken_q + 1) % 16;
                    if (taken_q >= SAMPLES) begin
                        rep = int'(batch_peak_q) + int'(MARGIN_TENTHS);
                        if (rep > int'(TEMP_TOP))
                            rep = int'(TEMP_TOP);
                        r.reported   = rep[TEMP_W-1:0];
                        r.temp_fail  = (rep >= int'($signed(threshold_q)));
                        r.batch_done = 1'b1;
                        sampling_q   = 0;
                        taken_q      = 0;
                        batch_peak_q = '0;
                    end
                end
                pos_q = 0;
            end
        end
    endtask

    // drive one item and wait for its transfer
    task automatic put(input logic [1:0] cmd, input logic [7:0] b, input logic first);
        bit fire;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {first, cmd};
        fire = 0;
        while (!fire) begin
            @(negedge aclk);
            fire = s_tvalid && s_tready;
            @(posedge aclk);
        end
    endtask

    task automatic send(input logic [1:0] cmd, input logic [7:0] b, input logic first);
        bit            has;
        frame_report_t r;
        put(cmd, b, first);
        predict_item(cmd, b, first, has, r);
        if (has)
            pending_reports.push_back(r);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // stop sending until every result is out, then give the pipe time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_config(input logic [6:0] addr, input logic [15:0] thr);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_DEV_ADDR;
        cfg_wdata <= {9'b0, addr};
        @(posedge aclk);
        cfg_addr  <= REG_THRESHOLD;
        cfg_wdata <= thr;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dev_addr_q  = addr;
        threshold_q = thr;
    endtask

    task automatic send_control(input logic [1:0] ctl);
        send(ctl, 8'($urandom), 1'($urandom));
    endtask

    // one well-formed frame with random content, sometimes corrupted or cut short, with the odd control item in between
    task automatic send_frame();
        logic [7:0]  frame_bytes [FRAME_LEN];
        logic [7:0]  c;
        logic [15:0] w;
        int          cut;
        int          k;
        logic        first;
        for (int i = 0; i < 1 + PIXELS; i++) begin
            case ($urandom_range(9))
                0:       w = 16'h8000;
                1:       w = 16'h7fff;
                2:       w = 16'hffff;
                3:       w = 16'h0000;
                4:       w = 16'($urandom);
                5:       w = 16'($urandom_range(32767, 32740));
                default: w = 16'($urandom_range(450, 0));
            endcase
            frame_bytes[2*i]   = w[7:0];
            frame_bytes[2*i+1] = w[15:8];
        end
        c = crc07({dev_addr_q, 1'b1});
        for (int j = 0; j < FRAME_LEN - 1; j++)
            c = crc07(c ^ frame_bytes[j]);
        frame_bytes[FRAME_LEN-1] = ($urandom_range(7) != 0) ? c
                                                            : c ^ 8'($urandom_range(255, 1));
        cut = ($urandom_range(24) == 0) ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN;
        for (int j = 0; j < cut; j++) begin
            if ($urandom_range(49) == 0) begin
                k = $urandom_range(2);
                send_control(k == 0 ? CMD_START : (k == 1 ? CMD_RESET_BATCH : CMD_UNUSED));
            end
            // an unmarked start is legal only when the parse sits at position zero
            first = (j == 0) ? (pos_q != 0 || $urandom_range(2) != 0) : 1'b0;
            send(CMD_FRAME_BYTE, frame_bytes[j], first);
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            if (mismatches < 10)
                $display("mismatch %s: expected %0d, got %0d at %0t",
                         name, want_v, got_v, $time);
            mismatches++;
        end
    endtask

    // result checking and watchdog on the falling edge, where handshakes are stable
    always @(negedge aclk) begin
        frame_report_t got;
        frame_report_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end else if (m_tvalid && m_tready) begin
                got = '{frame_done: m_tuser[0], pec_ok: m_tdata[0], ref_temp: m_tdata[16:1],
                        frame_peak: m_tdata[31:17], batch_done: m_tuser[1],
                        reported: m_tdata[46:32], temp_fail: m_tdata[47],
                        reset_done: m_tuser[2]};
                if (pending_reports.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %h at %0t", got, $time);
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("frame_done", want.frame_done, got.frame_done);
                    check_field("pec_ok", want.pec_ok, got.pec_ok);
                    check_field("reference_temp", want.ref_temp, got.ref_temp);
                    check_field("frame_peak", want.frame_peak, got.frame_peak);
                    check_field("batch_done", want.batch_done, got.batch_done);
                    check_field("reported_temp", want.reported, got.reported);
                    check_field("temp_fail", want.temp_fail, got.temp_fail);
                    check_field("reset_done", want.reset_done, got.reset_done);
                end
            end
        end
    end

    initial begin
        bit            has;
        frame_report_t r;
        int            roll;
        int            target;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        src_idle_pct = 36;
        snk_idle_pct = 61;
        items_sent   = 0;
        mismatches   = 0;
        stall_cycles = 0;
        dev_addr_q   = RESET_DEV_ADDR;
        threshold_q  = RESET_THRESHOLD;
        crc_q        = '0;
        pos_q        = 0;
        low_q        = '0;
        ref_q        = '0;
        peak_q       = '0;
        sampling_q   = 0;
        taken_q      = 0;
        batch_peak_q = '0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            put(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].first);
            predict_item(DIRECTED[i].cmd, DIRECTED[i].data, DIRECTED[i].first, has, r);
            if (DIRECTED[i].kind == ROW_ACK)
                pending_reports.push_back(RESET_ACK);
            else if (DIRECTED[i].kind == ROW_PREDICT && has)
                pending_reports.push_back(r);
        end

        for (int seg = 0; seg < 6; seg++) begin
            settle();
            case (seg / 2)
                0:       begin src_idle_pct = 36; snk_idle_pct = 61; end
                1:       begin src_idle_pct = 61; snk_idle_pct = 36; end
                default: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            endcase
            case (seg)
                0:       write_config(7'd0, 16'h8000);
                1:       write_config(7'd127, 16'h7fff);
                2:       write_config(7'($urandom), 16'd375);
                3:       write_config(7'($urandom), 16'd20);
                4:       write_config(7'($urandom), 16'($urandom));
                default: write_config(7'd10, 16'd21);
            endcase
            target = items_sent + SEG_ITEMS;
            while (items_sent < target) begin
                roll = $urandom_range(99);
                if (roll < 68) begin
                    send_frame();
                end else if (roll < 80) begin
                    send_control(CMD_START);
                end else if (roll < 86) begin
                    send_control(CMD_RESET_BATCH);
                end else if (roll < 90) begin
                    send_control(CMD_UNUSED);
                end else begin
                    // loose bytes with the odd restart mark
                    repeat ($urandom_range(12, 1))
                        send(CMD_FRAME_BYTE, 8'($urandom), ($urandom_range(7) == 0));
                end
            end
        end

        settle();
        if (pending_reports.size() != 0) begin
            $display("%0d results never arrived", pending_reports.size());
            mismatches += pending_reports.size();
        end
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
